### rtl/core/psb_pkg.sv
package psb_pkg;

  // Default period depth
  localparam int MAX_PERIOD_DEF = 16;

  // Field widths
  localparam int OP_W     = 2;
  localparam int WEIGHT_W = 16;
  localparam int SLOT_W   = 4;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int ACC_W    = 32;
  localparam int CNT_W    = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_SKIP   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OOS   = 2'd3;

  // Period register value after reset
  localparam logic [CFG_W-1:0] PERIOD_RESET = 5'd1;

endpackage

### rtl/core/psb_in_if.sv
interface psb_in_if;
  logic                          valid;
  logic                          ready;
  logic [psb_pkg::OP_W-1:0]      op;
  logic                          relaxed_policy;
  logic [psb_pkg::WEIGHT_W-1:0]  item_weight;
  logic [psb_pkg::SLOT_W-1:0]    target_slot;
  logic [psb_pkg::TICK_W-1:0]    tick_value;

  modport source (output valid, op, relaxed_policy, item_weight, target_slot, tick_value,
                  input ready);
  modport sink (input valid, op, relaxed_policy, item_weight, target_slot, tick_value,
                output ready);
endinterface

### rtl/core/psb_out_if.sv
interface psb_out_if;
  logic                          valid;
  logic                          ready;
  logic [psb_pkg::SLOT_W-1:0]    slot_index;
  logic                          activate;
  logic [psb_pkg::STATUS_W-1:0]  status;
  logic                          all_empty;

  modport source (output valid, slot_index, activate, status, all_empty, input ready);
  modport sink (input valid, slot_index, activate, status, all_empty, output ready);
endinterface

### rtl/core/periodic_slot_balancer.sv
// Least-loaded sub-slot assignment over a periodic schedule.
// Requests arrive on in_item (valid/ready); one result beat per request leaves on
// out_item. cfg_wr_en/cfg_wr_data write the period length (sub-slots in use);
// write it only while the block is idle.
// Add: strict requests go to the sub-slot after the current one, relaxed requests
// to the lightest sub-slot. Remove takes weight and count from a named sub-slot.
// Tick maps tick_value onto a sub-slot and activates it unless it is already the
// current one in a period above 1; skip only moves it. Work is done by one shared
// restoring-remainder unit (one bit a cycle) and by one-read-a-cycle scans of the
// sub-slot store; per request the steps are:
//   add strict   : remainder pass, read, write
//   add relaxed  : scan for the lightest sub-slot, read, write
//   remove       : read, write, empty scan (only the scan outside the period)
//   tick / skip  : remainder pass on tick_value (+ one on activation), empty scan
// The block takes one request at a time: in_item.ready is high only when no
// request is in work and no result is waiting, so the next request can be taken
// in the cycle after the result beat leaves. Reset clears all sub-slot totals
// (per-entry valid bits), the current sub-slot and sets the period to 1; the block is ready the cycle after reset.
// A stalled receiver holds the result beat on out_item and no new request is taken.
module periodic_slot_balancer #(
  parameter int MAX_PERIOD = psb_pkg::MAX_PERIOD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  psb_in_if.sink                    in_item,
  psb_out_if.source                 out_item,
  input  logic                      cfg_wr_en,
  input  logic [psb_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int SW  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int PEW = $clog2(MAX_PERIOD + 1);
  localparam int CW  = SW + 1;
  localparam int TW  = psb_pkg::TICK_W;
  localparam int AW  = psb_pkg::ACC_W;
  localparam int NW  = psb_pkg::CNT_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_MIN   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // What a remainder pass computes
  localparam logic [1:0] MT_ADD  = 2'd0;
  localparam logic [1:0] MT_TICK = 2'd1;
  localparam logic [1:0] MT_EXP  = 2'd2;

  logic [2:0]                   state_r, state_nxt;
  logic [psb_pkg::CFG_W-1:0]    pl_r;
  logic [SW-1:0]                cur_r, cur_nxt;
  logic [MAX_PERIOD-1:0]        vld_r;

  logic [psb_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [psb_pkg::WEIGHT_W-1:0] w_r, w_nxt;
  logic                         tick_nz_r, tick_nz_nxt;

  logic [1:0]                   mt_r, mt_nxt;
  logic [TW-1:0]                div_r, div_nxt;
  logic [PEW-1:0]               rem_r, rem_nxt;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic [SW-1:0]                d_r, d_nxt;
  logic [SW-1:0]                idx_r, idx_nxt;
  logic [PEW-1:0]               sc_r, sc_nxt;
  logic                         pv_r, pv_nxt;
  logic [SW-1:0]                pa_r, pa_nxt;
  logic [AW-1:0]                best_r, best_nxt;
  logic                         emp_r, emp_nxt;

  logic [psb_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                         res_act_r, res_act_nxt;
  logic [psb_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;

  // Sub-slot store and its registered read port
  logic [AW-1:0]                wmem [MAX_PERIOD];
  logic [NW-1:0]                cmem [MAX_PERIOD];
  logic [AW-1:0]                rd_w_q;
  logic [NW-1:0]                rd_c_q;
  logic                         rd_v_q;
  logic [SW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_w;
  logic [NW-1:0]                wr_c;

  logic [PEW-1:0]               p;
  logic                         p_one;
  logic [AW-1:0]                eff_w;
  logic [NW-1:0]                eff_c;
  logic [PEW:0]                 t;
  logic [PEW-1:0]               rem_step;
  logic [SW-1:0]                rem_slot;
  logic [CW-1:0]                cur_p1;
  logic                         scan_more;
  logic [AW:0]                  sum_w;

  // Effective period
  always_comb begin
    if (pl_r == '0) begin
      p = PEW'(1);
    end else if (32'(pl_r) > 32'(MAX_PERIOD)) begin
      p = PEW'(MAX_PERIOD);
    end else begin
      p = PEW'(pl_r);
    end
  end

  assign p_one     = (p == PEW'(1));
  assign eff_w     = rd_v_q ? rd_w_q : '0;
  assign eff_c     = rd_v_q ? rd_c_q : '0;
  assign scan_more = (sc_r < p);
  assign cur_p1    = CW'(cur_r) + CW'(1);

  // One restoring remainder step: bring in the next dividend bit, subtract if it fits
  assign t        = {rem_r, div_r[TW-1]};
  assign rem_step = (t >= {1'b0, p}) ? PEW'(t - {1'b0, p}) : PEW'(t);
  assign rem_slot = SW'(rem_step);

  assign sum_w = {1'b0, eff_w} + (AW + 1)'(w_r);

  assign rd_addr = (state_r == S_RD) ? idx_r : SW'(sc_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    op_nxt       = op_r;
    w_nxt        = w_r;
    tick_nz_nxt  = tick_nz_r;
    mt_nxt       = mt_r;
    div_nxt      = div_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    d_nxt        = d_r;
    idx_nxt      = idx_r;
    sc_nxt       = sc_r;
    pv_nxt       = pv_r;
    pa_nxt       = pa_r;
    best_nxt     = best_r;
    emp_nxt      = emp_r;
    res_slot_nxt = res_slot_r;
    res_act_nxt  = res_act_r;
    res_st_nxt   = res_st_r;
    wr_en        = 1'b0;
    wr_w         = eff_w;
    wr_c         = eff_c;

    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          op_nxt       = in_item.op;
          w_nxt        = in_item.item_weight;
          tick_nz_nxt  = (in_item.tick_value != '0);
          res_act_nxt  = 1'b0;
          res_st_nxt   = psb_pkg::ST_OK;
          res_slot_nxt = in_item.target_slot;
          emp_nxt      = 1'b1;
          sc_nxt       = '0;
          pv_nxt       = 1'b0;
          rem_nxt      = '0;
          unique case (in_item.op) inside
            psb_pkg::OP_ADD: begin
              if (in_item.relaxed_policy) begin
                state_nxt = S_MIN;
              end else begin
                mt_nxt    = MT_ADD;
                div_nxt   = {cur_p1, {(TW - CW){1'b0}}};
                cnt_nxt   = 6'(CW);
                state_nxt = S_MOD;
              end
            end
            psb_pkg::OP_REMOVE: begin
              if (32'(in_item.target_slot) >= 32'(p)) begin
                res_st_nxt = psb_pkg::ST_UNDER;
                state_nxt  = S_EMPTY;
              end else begin
                idx_nxt   = SW'(in_item.target_slot);
                state_nxt = S_RD;
              end
            end
            psb_pkg::OP_TICK, psb_pkg::OP_SKIP: begin
              mt_nxt    = MT_TICK;
              div_nxt   = in_item.tick_value;
              cnt_nxt   = 6'(TW);
              state_nxt = S_MOD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_MOD: begin
        div_nxt = div_r << 1;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          unique case (mt_r)
            MT_ADD: begin
              idx_nxt   = rem_slot;
              state_nxt = S_RD;
            end
            MT_TICK: begin
              if (op_r == psb_pkg::OP_SKIP) begin
                cur_nxt      = rem_slot;
                res_slot_nxt = psb_pkg::SLOT_W'(rem_slot);
                state_nxt    = S_EMPTY;
              end else if (cur_r != rem_slot || p_one) begin
                // activation: work out the expected next sub-slot
                d_nxt     = rem_slot;
                mt_nxt    = MT_EXP;
                div_nxt   = {cur_p1, {(TW - CW){1'b0}}};
                rem_nxt   = '0;
                cnt_nxt   = 6'(CW);
                state_nxt = S_MOD;
              end else begin
                res_st_nxt   = tick_nz_r ? psb_pkg::ST_DUP : psb_pkg::ST_OK;
                res_slot_nxt = psb_pkg::SLOT_W'(cur_r);
                state_nxt    = S_EMPTY;
              end
            end
            MT_EXP: begin
              res_st_nxt   = (rem_slot != d_r) ? psb_pkg::ST_OOS : psb_pkg::ST_OK;
              cur_nxt      = d_r;
              res_act_nxt  = 1'b1;
              res_slot_nxt = psb_pkg::SLOT_W'(d_r);
              state_nxt    = S_EMPTY;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_MIN: begin
        // issue one read a cycle, compare the beat read the cycle before
        if (scan_more) begin
          sc_nxt = sc_r + PEW'(1);
        end
        pv_nxt = scan_more;
        pa_nxt = SW'(sc_r);
        if (pv_r && (pa_r == '0 || eff_w < best_r)) begin
          best_nxt = eff_w;
          idx_nxt  = pa_r;
        end
        if (!scan_more) begin
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        state_nxt = S_WR;
      end

      S_WR: begin
        wr_en = 1'b1;
        if (op_r == psb_pkg::OP_ADD) begin
          wr_w         = sum_w[AW] ? '1 : sum_w[AW-1:0];
          wr_c         = (eff_c == '1) ? eff_c : eff_c + NW'(1);
          res_slot_nxt = psb_pkg::SLOT_W'(idx_r);
          emp_nxt      = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          if (eff_w < AW'(w_r)) begin
            wr_w       = '0;
            res_st_nxt = psb_pkg::ST_UNDER;
          end else begin
            wr_w = eff_w - AW'(w_r);
          end
          if (eff_c == '0) begin
            res_st_nxt = psb_pkg::ST_UNDER;
          end else begin
            wr_c = eff_c - NW'(1);
          end
          sc_nxt    = '0;
          pv_nxt    = 1'b0;
          state_nxt = S_EMPTY;
        end
      end

      S_EMPTY: begin
        if (scan_more) begin
          sc_nxt = sc_r + PEW'(1);
        end
        pv_nxt = scan_more;
        pa_nxt = SW'(sc_r);
        if (pv_r && eff_c != '0) begin
          emp_nxt = 1'b0;
        end
        if (!scan_more) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_item.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      pl_r    <= psb_pkg::PERIOD_RESET;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      if (cfg_wr_en) begin
        pl_r <= cfg_wr_data;
      end
      if (wr_en) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    w_r        <= w_nxt;
    tick_nz_r  <= tick_nz_nxt;
    mt_r       <= mt_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    d_r        <= d_nxt;
    idx_r      <= idx_nxt;
    sc_r       <= sc_nxt;
    pv_r       <= pv_nxt;
    pa_r       <= pa_nxt;
    best_r     <= best_nxt;
    emp_r      <= emp_nxt;
    res_slot_r <= res_slot_nxt;
    res_act_r  <= res_act_nxt;
    res_st_r   <= res_st_nxt;
  end

  // Sub-slot store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[idx_r] <= wr_w;
      cmem[idx_r] <= wr_c;
    end
    rd_w_q <= wmem[rd_addr];
    rd_c_q <= cmem[rd_addr];
    rd_v_q <= vld_r[rd_addr];
  end

  // Channel handshakes
  assign in_item.ready       = (state_r == S_IDLE);
  assign out_item.valid      = (state_r == S_OUT);
  assign out_item.slot_index = res_slot_r;
  assign out_item.activate   = res_act_r;
  assign out_item.status     = res_st_r;
  assign out_item.all_empty  = emp_r;

endmodule
